/* src/bam_pkg.sv */
// Package for the block average mosaic: field widths, register codes,
// the block tag carried with each result and the divider state type.
// No dependencies; the other files but bam_column_ram refer to it by scoped names.
package bam_pkg;

   localparam int PIXEL_W      = 8;
   localparam int POS_W        = 10;
   localparam int FRAME_REG_W  = 11;
   localparam int BLOCK_REG_W  = 7;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 11;
   localparam int HEIGHT_LIMIT = 1024;
   localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
   localparam int WIDTH_RESET  = 512;
   localparam int HEIGHT_RESET = 512;
   localparam int BLOCK_RESET  = 8;
   localparam int AVG_MAX      = 255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_BLOCK_SIZE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [POS_W-1:0] block_row;
      logic [POS_W-1:0] block_col;
      logic             frame_last;
   } block_tag_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // A zero setting acts as one and a setting above the limit as the limit.
   function automatic int unsigned clamp_minus_one(input int unsigned value,
                                                   input int unsigned limit);
      int unsigned result;
      if (value == 0) begin
         result = 0;
      end else if (value > limit) begin
         result = limit - 1;
      end else begin
         result = value - 1;
      end
      return result;
   endfunction

endpackage

/* src/bam_if.sv */
// Channel interfaces of the block average mosaic: pixel input, block result
// output and register write port. Depends on bam_pkg for the field widths.
interface bam_req_if;
   logic                         valid;
   logic                         ready;
   logic [bam_pkg::PIXEL_W-1:0]  pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface bam_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bam_pkg::POS_W-1:0]    block_row;
   logic [bam_pkg::POS_W-1:0]    block_col;
   logic [bam_pkg::PIXEL_W-1:0]  average;
   logic                         frame_last;

   modport source (output valid, output block_row, output block_col, output average,
                   output frame_last, input ready);
   modport sink   (input valid, input block_row, input block_col, input average,
                   input frame_last, output ready);
endinterface

interface bam_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bam_pkg::CSR_INDEX_W-1:0] index;
   logic [bam_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/bam_column_ram.sv */
// Column sum memory of the block average mosaic: one write port and one
// read port with registered read data. No package dependencies.
module bam_column_ram #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] column_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         column_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= column_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/bam_divider.sv */
// Radix-two restoring divider of the block average mosaic, one quotient bit
// per cycle, with the mean saturated to the pixel range. Uses bam_pkg.
module bam_divider #(
   parameter int DIVIDEND_W = 20,
   parameter int DIVISOR_W  = 13
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DIVIDEND_W-1:0]        dividend,
   input  logic [DIVISOR_W-1:0]         divisor,
   input  bam_pkg::block_tag_type       start_tag,
   output logic                         busy,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [bam_pkg::PIXEL_W-1:0]  quotient,
   output bam_pkg::block_tag_type       done_tag
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   bam_pkg::div_state_type state_ff, state_in;
   logic [DIVIDEND_W-1:0]  quo_ff, quo_in;
   logic [DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [DIVISOR_W-1:0]   dsr_ff, dsr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   bam_pkg::block_tag_type tag_ff, tag_in;
   logic [DIVISOR_W:0]     rem_shift;
   logic                   fits;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bam_pkg::DIV_IDLE: begin
            if (start) begin
               state_in = bam_pkg::DIV_RUN;
            end
         end
         bam_pkg::DIV_RUN: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = bam_pkg::DIV_DONE;
            end
         end
         bam_pkg::DIV_DONE: begin
            if (out_ready) begin
               state_in = bam_pkg::DIV_IDLE;
            end
         end
         default: begin
            state_in = bam_pkg::DIV_IDLE;
         end
      endcase
   end

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits      = rem_shift >= {1'b0, dsr_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      cnt_in    = cnt_ff;
      tag_in    = tag_ff;
      busy      = 1'b1;
      out_valid = 1'b0;
      case (state_ff)
         bam_pkg::DIV_IDLE: begin
            busy = 1'b0;
            if (start) begin
               quo_in = dividend;
               rem_in = '0;
               dsr_in = divisor;
               cnt_in = CNT_W'(DIVIDEND_W);
               tag_in = start_tag;
            end
         end
         bam_pkg::DIV_RUN: begin
            rem_in = fits ? DIVISOR_W'(rem_shift - {1'b0, dsr_ff}) : rem_shift[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         bam_pkg::DIV_DONE: begin
            out_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bam_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      tag_ff <= tag_in;
   end

   assign quotient = (|quo_ff[DIVIDEND_W-1:bam_pkg::PIXEL_W]) ?
                     bam_pkg::PIXEL_W'(bam_pkg::AVG_MAX) : quo_ff[bam_pkg::PIXEL_W-1:0];
   assign done_tag = tag_ff;

endmodule

/* src/block_average_mosaic.sv */
// Top level of the block average mosaic: raster counters, column sum
// read-modify-write, divider and result register. Uses bam_pkg, bam_if,
// bam_column_ram and bam_divider.
//
//   channel  direction  contents                                   handshake
//   req_ch   in         pixel                                      valid/ready
//   rsp_ch   out        block_row, block_col, average, frame_last  valid/ready
//   csr_ch   in         index, data (0 width, 1 height, 2 block)   valid/ready
//
// A pixel that does not finish a block does not stall the input; the column sum
// is read from the memory in the cycle of the transaction and, for a pixel that
// ends a block's row, written back in the next. A pixel that finishes a block
// holds req_ch.ready low while the divider produces one quotient bit a cycle.
// Reset is synchronous; it loads the registers with 512, 512 and 8 and clears the
// counters. The column memory is not cleared. A result waiting in the output
// register stalls the input only when a further block finishes.
module block_average_mosaic #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_BLOCK = 64
) (
   input  logic        clock,
   input  logic        reset,
   bam_req_if.sink     req_ch,
   bam_rsp_if.source   rsp_ch,
   bam_csr_if.sink     csr_ch
);

   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int BW  = $clog2(MAX_BLOCK);
   localparam int BW1 = BW + 1;
   localparam int RW  = bam_pkg::ROW_W;
   localparam int PW  = bam_pkg::PIXEL_W + BW;
   localparam int SW  = bam_pkg::PIXEL_W + 2 * BW;
   localparam int CW  = 2 * BW + 1;

   logic [XW-1:0] width_m1_ff, width_m1_in;
   logic [RW-1:0] height_m1_ff, height_m1_in;
   logic [BW-1:0] block_m1_ff, block_m1_in;

   logic [XW-1:0] pixel_x_ff, pixel_x_in;
   logic [RW-1:0] pixel_y_ff, pixel_y_in;
   logic [BW-1:0] x_in_block_ff, x_in_block_in;
   logic [BW-1:0] y_in_block_ff, y_in_block_in;
   logic [XW-1:0] block_col_ff, block_col_in;
   logic [RW-1:0] block_row_ff, block_row_in;
   logic [PW-1:0] partial_ff, partial_in;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_hblock_ff, s1_hblock_in;
   logic                   s1_vblock_ff, s1_vblock_in;
   logic                   s1_top_ff, s1_top_in;
   logic                   s1_fwd_ff, s1_fwd_in;
   logic [XW-1:0]          s1_idx_ff, s1_idx_in;
   logic [PW-1:0]          s1_partial_ff, s1_partial_in;
   logic [SW-1:0]          s1_fwd_sum_ff, s1_fwd_sum_in;
   logic [CW-1:0]          s1_count_ff, s1_count_in;
   bam_pkg::block_tag_type s1_tag_ff, s1_tag_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bam_pkg::PIXEL_W-1:0]  rsp_avg_ff, rsp_avg_in;
   bam_pkg::block_tag_type       rsp_tag_ff, rsp_tag_in;

   logic                         accept;
   logic                         row_end;
   logic                         frame_end;
   logic                         hblock_end;
   logic                         vblock_end;
   logic [PW-1:0]                row_sum;
   logic [BW1-1:0]               cnt_x;
   logic [BW1-1:0]               cnt_y;
   logic [2*BW1-1:0]             cnt_prod;
   logic [SW-1:0]                ram_rd;
   logic [SW-1:0]                sum_base;
   logic [SW-1:0]                col_sum;
   logic                         div_busy;
   logic                         div_valid;
   logic                         div_ready;
   logic [bam_pkg::PIXEL_W-1:0]  div_quotient;
   bam_pkg::block_tag_type       div_tag;

   // Register writes; the stored values are already clamped and less one.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      width_m1_in  = width_m1_ff;
      height_m1_in = height_m1_ff;
      block_m1_in  = block_m1_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            bam_pkg::CSR_FRAME_WIDTH: begin
               width_m1_in = XW'(bam_pkg::clamp_minus_one(32'(csr_ch.data), MAX_WIDTH));
            end
            bam_pkg::CSR_FRAME_HEIGHT: begin
               height_m1_in = RW'(bam_pkg::clamp_minus_one(32'(csr_ch.data),
                                                           bam_pkg::HEIGHT_LIMIT));
            end
            bam_pkg::CSR_BLOCK_SIZE: begin
               block_m1_in = BW'(bam_pkg::clamp_minus_one(
                                 32'(csr_ch.data[bam_pkg::BLOCK_REG_W-1:0]), MAX_BLOCK));
            end
            default: begin
               width_m1_in = width_m1_ff;
            end
         endcase
      end
   end

   assign req_ch.ready = !div_busy && !(s1_valid_ff && s1_vblock_ff);
   assign accept       = req_ch.valid && req_ch.ready;

   assign row_end    = pixel_x_ff >= width_m1_ff;
   assign frame_end  = row_end && (pixel_y_ff >= height_m1_ff);
   assign hblock_end = row_end || (x_in_block_ff >= block_m1_ff);
   assign vblock_end = (y_in_block_ff >= block_m1_ff) || (pixel_y_ff >= height_m1_ff);
   assign row_sum    = partial_ff + PW'(req_ch.pixel);
   assign cnt_x      = BW1'(x_in_block_ff) + BW1'(1);
   assign cnt_y      = BW1'(y_in_block_ff) + BW1'(1);
   assign cnt_prod   = cnt_x * cnt_y;

   always_comb begin
      pixel_x_in    = pixel_x_ff;
      pixel_y_in    = pixel_y_ff;
      x_in_block_in = x_in_block_ff;
      y_in_block_in = y_in_block_ff;
      block_col_in  = block_col_ff;
      block_row_in  = block_row_ff;
      partial_in    = partial_ff;
      if (accept) begin
         partial_in = hblock_end ? '0 : row_sum;
         if (row_end) begin
            pixel_x_in    = '0;
            x_in_block_in = '0;
            block_col_in  = '0;
            if (frame_end) begin
               pixel_y_in    = '0;
               y_in_block_in = '0;
               block_row_in  = '0;
            end else begin
               pixel_y_in = pixel_y_ff + RW'(1);
               if (vblock_end) begin
                  y_in_block_in = '0;
                  block_row_in  = block_row_ff + RW'(1);
               end else begin
                  y_in_block_in = y_in_block_ff + BW'(1);
               end
            end
         end else begin
            pixel_x_in = pixel_x_ff + XW'(1);
            if (hblock_end) begin
               x_in_block_in = '0;
               block_col_in  = block_col_ff + XW'(1);
            end else begin
               x_in_block_in = x_in_block_ff + BW'(1);
            end
         end
      end
   end

   // Second stage: the column sum read in the transaction cycle arrives here.
   // A write to the same column in the cycle of that read is forwarded.
   always_comb begin
      s1_valid_in   = accept;
      s1_hblock_in  = hblock_end;
      s1_vblock_in  = hblock_end && vblock_end;
      s1_top_in     = y_in_block_ff == '0;
      s1_idx_in     = block_col_ff;
      s1_partial_in = row_sum;
      s1_fwd_in     = s1_valid_ff && s1_hblock_ff && (s1_idx_ff == block_col_ff);
      s1_fwd_sum_in = col_sum;
      s1_count_in   = CW'(cnt_prod);
      s1_tag_in     = '{block_row:  bam_pkg::POS_W'(block_row_ff),
                        block_col:  bam_pkg::POS_W'(block_col_ff),
                        frame_last: frame_end};
   end

   assign sum_base = s1_top_ff ? '0 : (s1_fwd_ff ? s1_fwd_sum_ff : ram_rd);
   assign col_sum  = sum_base + SW'(s1_partial_ff);

   bam_column_ram #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (SW)
   ) u_column_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff && s1_hblock_ff),
      .wr_addr (s1_idx_ff),
      .wr_data (col_sum),
      .rd_addr (block_col_ff),
      .rd_data (ram_rd)
   );

   bam_divider #(
      .DIVIDEND_W (SW),
      .DIVISOR_W  (CW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (s1_valid_ff && s1_vblock_ff),
      .dividend  (col_sum),
      .divisor   (s1_count_ff),
      .start_tag (s1_tag_ff),
      .busy      (div_busy),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .quotient  (div_quotient),
      .done_tag  (div_tag)
   );

   assign div_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_avg_in   = rsp_avg_ff;
      rsp_tag_in   = rsp_tag_ff;
      if (div_valid && div_ready) begin
         rsp_valid_in = 1'b1;
         rsp_avg_in   = div_quotient;
         rsp_tag_in   = div_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_m1_ff   <= XW'(bam_pkg::clamp_minus_one(bam_pkg::WIDTH_RESET, MAX_WIDTH));
         height_m1_ff  <= RW'(bam_pkg::clamp_minus_one(bam_pkg::HEIGHT_RESET,
                                                       bam_pkg::HEIGHT_LIMIT));
         block_m1_ff   <= BW'(bam_pkg::clamp_minus_one(bam_pkg::BLOCK_RESET, MAX_BLOCK));
         pixel_x_ff    <= '0;
         pixel_y_ff    <= '0;
         x_in_block_ff <= '0;
         y_in_block_ff <= '0;
         block_col_ff  <= '0;
         block_row_ff  <= '0;
         partial_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_m1_ff   <= width_m1_in;
         height_m1_ff  <= height_m1_in;
         block_m1_ff   <= block_m1_in;
         pixel_x_ff    <= pixel_x_in;
         pixel_y_ff    <= pixel_y_in;
         x_in_block_ff <= x_in_block_in;
         y_in_block_ff <= y_in_block_in;
         block_col_ff  <= block_col_in;
         block_row_ff  <= block_row_in;
         partial_ff    <= partial_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      s1_hblock_ff  <= s1_hblock_in;
      s1_vblock_ff  <= s1_vblock_in;
      s1_top_ff     <= s1_top_in;
      s1_fwd_ff     <= s1_fwd_in;
      s1_idx_ff     <= s1_idx_in;
      s1_partial_ff <= s1_partial_in;
      s1_fwd_sum_ff <= s1_fwd_sum_in;
      s1_count_ff   <= s1_count_in;
      s1_tag_ff     <= s1_tag_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_tag_ff    <= rsp_tag_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.block_row  = rsp_tag_ff.block_row;
   assign rsp_ch.block_col  = rsp_tag_ff.block_col;
   assign rsp_ch.average    = rsp_avg_ff;
   assign rsp_ch.frame_last = rsp_tag_ff.frame_last;

endmodule

/* src/bam_checker.sv */
// Port-level checker for the block average mosaic and its bind to the top
// level. Depends on bam_pkg for field widths and on block_average_mosaic.
module bam_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bam_pkg::POS_W-1:0]    rsp_block_row,
   input logic [bam_pkg::POS_W-1:0]    rsp_block_col,
   input logic [bam_pkg::PIXEL_W-1:0]  rsp_average,
   input logic                         rsp_frame_last
);

   // No result can be pending straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered in the cycle after reset");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before its transaction");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_ready |=> $stable(rsp_block_row) &&
                    $stable(rsp_block_col) && $stable(rsp_average) &&
                    $stable(rsp_frame_last))
      else $error("result payload changed while stalled");

   // A new result only follows a division, during which no pixel is taken.
   assert property (@(posedge clock) disable iff (reset)
                    $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("pixel transaction in the cycle before a new result");

endmodule

bind block_average_mosaic bam_checker u_bam_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_block_row  (rsp_ch.block_row),
   .rsp_block_col  (rsp_ch.block_col),
   .rsp_average    (rsp_ch.average),
   .rsp_frame_last (rsp_ch.frame_last)
);
